### rtl/png_idat_stored_zlib_encoder_top_assert.svh
// Assertion macros for the IDAT encoder top level.
`ifndef PNG_IDAT_STORED_ZLIB_ENCODER_TOP_ASSERT_SVH
`define PNG_IDAT_STORED_ZLIB_ENCODER_TOP_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define PNGIDAT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define PNGIDAT_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/pngidat_pkg.sv
// Types, constants and helper functions of the IDAT encoder.
package pngidat_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    MODE_BEGIN  = 2'd0,
    MODE_PIXEL  = 2'd1,
    MODE_END    = 2'd2,
    MODE_IGNORE = 2'd3
  } mode_t;

  // Configuration register indexes
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD       = 17'd65521;
  localparam logic [31:0] MAX_BLOCK_BYTES = 32'd65535;
  localparam logic [31:0] CHUNK_TYPE      = 32'h49444154;  // "IDAT"
  localparam logic [7:0]  ZLIB_CMF        = 8'h78;
  localparam logic [7:0]  ZLIB_FLG        = 8'h01;

  // Sequencer step marks of a begin transaction
  localparam logic [3:0] BEGIN_LEN_STEP  = 4'd2;   // first length byte, after the length compute
  localparam logic [3:0] BEGIN_TAG_STEP  = 4'd6;
  localparam logic [3:0] BEGIN_ZLIB_STEP = 4'd10;
  localparam logic [3:0] BEGIN_LAST_STEP = 4'd11;
  // Sequencer step marks of an end transaction
  localparam logic [3:0] END_CRC_STEP    = 4'd4;
  localparam logic [3:0] END_LAST_STEP   = 4'd7;
  // Last byte of a stored-block header
  localparam logic [3:0] HDR_LAST_STEP   = 4'd4;

  // CRC-32 (reflected) over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  // Big-endian byte of a word, index 0 is the top byte
  function automatic logic [7:0] be32_byte(input logic [31:0] word, input logic [1:0] idx);
    logic [7:0] r;
    unique case (idx)
      2'd0: r = word[31:24];
      2'd1: r = word[23:16];
      2'd2: r = word[15:8];
      default: r = word[7:0];
    endcase
    return r;
  endfunction

  // Stored-block header byte: BFINAL, LEN low/high, NLEN low/high
  function automatic logic [7:0] hdr_byte(input logic bfinal, input logic [15:0] blen,
                                          input logic [2:0] idx);
    logic [15:0] nlen;
    logic [7:0]  r;
    nlen = ~blen;
    unique case (idx)
      3'd0: r = {7'd0, bfinal};
      3'd1: r = blen[7:0];
      3'd2: r = blen[15:8];
      3'd3: r = nlen[7:0];
      default: r = nlen[15:8];
    endcase
    return r;
  endfunction

endpackage

### rtl/pngidat_if.sv
// Valid/ready channel interfaces for input items and output bytes.
interface pngidat_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] pixel_index;
  modport source (output valid, mode, pixel_index, input ready);
  modport sink   (input valid, mode, pixel_index, output ready);
endinterface

interface pngidat_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  modport source (output valid, out_byte, run_last, input ready);
  modport sink   (input valid, out_byte, run_last, output ready);
endinterface

### rtl/png_idat_stored_zlib_encoder_top.sv
// IDAT chunk encoder: stored-deflate zlib stream with Adler-32 and CRC-32.
//
// Usage:
//   items  : input transactions. mode 0 begins a chunk, mode 1 carries one
//            palette index, mode 2 ends the chunk, mode 3 is dropped.
//   stream : one chunk byte per transaction; run_last marks the final byte
//            that an input transaction produced.
//   cfg    : image_width (index 0) and image_height (index 1), written while
//            the block is idle.
// Timing:
//   An item sits in the item register, then its bytes leave at one per
//   cycle while stream is not stalled: a pixel or an end emits from its
//   first sequencer step, a begin only from its first length byte.
//   A pixel emits its byte, plus the filter byte at a row start and the 5
//   bytes of each stored-block header. A begin forms the chunk length
//   through the multiply and block-count pipeline, then 10 bytes; an end 8.
//   The sequencer emits at most one byte per cycle, none in a stall; that sets the rate.
//   A new item is taken in the cycle the previous one emits its last byte.
// Reset clears the control and encoder state; CRC to all ones, Adler to 1.
// A stall on stream holds the output register and the sequencer, and items back up.
`include "png_idat_stored_zlib_encoder_top_assert.svh"

module png_idat_stored_zlib_encoder_top
  import pngidat_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  pngidat_in_if.sink           items,
  pngidat_out_if.source        stream
);

  // Configuration
  logic [15:0] image_width;
  logic [15:0] image_height;

  // Chunk length pipeline
  logic [32:0] raw_prod;
  logic [31:0] raw_reg;
  logic [31:0] len_reg;
  logic [16:0] fold_sum;
  logic [17:0] blk_quot;
  logic        blk_rem_nz;
  logic [17:0] blk_count;
  logic [31:0] len_next;

  // Encoder state
  logic [31:0] crc, crc_next;
  logic [15:0] adler_low, adler_low_next;
  logic [15:0] adler_high, adler_high_next;
  logic [31:0] raw_left, raw_left_next;
  logic [15:0] block_left, block_left_next;
  logic [15:0] column, column_next;

  // Item register and sequencer
  logic        item_valid;
  mode_t       item_mode;
  logic [7:0]  item_pixel;
  logic [3:0]  step, step_next;
  logic        filter_done, filter_done_next;

  // Output register
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;

  // Per-cycle action
  logic        adv;
  logic        emit;
  logic [7:0]  emit_byte;
  logic        emit_last;
  logic        fold;
  logic        done;

  // Pixel helpers
  logic        in_hdr;
  logic        bfinal;
  logic [15:0] blen;
  logic        filter_now;
  logic [7:0]  raw_b;
  logic [16:0] lo_sum, lo_mod, hi_sum, hi_mod;
  logic [16:0] col_inc;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 16'd1;
      image_height <= 16'd1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
      endcase
    end
  end

  // Raw size: one filter byte plus width pixels per row
  assign raw_prod = image_height * ({1'b0, image_width} + 17'd1);

  // Blocks of 2^16-1: raw = a*2^16 + b = a*(2^16-1) + (a+b)
  assign fold_sum = {1'b0, raw_reg[31:16]} + {1'b0, raw_reg[15:0]};
  always_comb begin
    if (fold_sum == 17'd131070) begin
      blk_quot   = {2'd0, raw_reg[31:16]} + 18'd2;
      blk_rem_nz = 1'b0;
    end else if (fold_sum >= MAX_BLOCK_BYTES[16:0]) begin
      blk_quot   = {2'd0, raw_reg[31:16]} + 18'd1;
      blk_rem_nz = (fold_sum != MAX_BLOCK_BYTES[16:0]);
    end else begin
      blk_quot   = {2'd0, raw_reg[31:16]};
      blk_rem_nz = (fold_sum != 17'd0);
    end
    blk_count = blk_quot + {17'd0, blk_rem_nz};
    // An empty image still carries one header in the length
    if (raw_reg == 32'd0) begin
      blk_count = 18'd1;
    end
    len_next = raw_reg + {12'd0, blk_count, 2'b00} + {14'd0, blk_count} + 32'd6;
  end

  always_ff @(posedge clk) begin
    raw_reg <= raw_prod[31:0];
    len_reg <= len_next;
  end

  // Stored-block header and raw byte selection
  assign in_hdr     = (block_left == 16'd0) && (raw_left != 32'd0);
  assign bfinal     = (raw_left <= MAX_BLOCK_BYTES);
  assign blen       = bfinal ? raw_left[15:0] : MAX_BLOCK_BYTES[15:0];
  assign filter_now = (column == 16'd0) && !filter_done;
  assign raw_b      = filter_now ? 8'h00 : item_pixel;

  // Adler-32 update, sums stay below twice the modulus
  assign lo_sum  = {1'b0, adler_low} + {9'd0, raw_b};
  assign lo_mod  = (lo_sum >= ADLER_MOD) ? lo_sum - ADLER_MOD : lo_sum;
  assign hi_sum  = {1'b0, adler_high} + lo_mod;
  assign hi_mod  = (hi_sum >= ADLER_MOD) ? hi_sum - ADLER_MOD : hi_sum;
  assign col_inc = {1'b0, column} + 17'd1;

  assign adv = item_valid && (!out_valid || stream.ready);

  // Byte sequencer
  always_comb begin
    emit             = 1'b0;
    emit_byte        = 8'h00;
    emit_last        = 1'b0;
    fold             = 1'b0;
    done             = 1'b0;
    step_next        = step + 4'd1;
    filter_done_next = filter_done;
    crc_next         = crc;
    adler_low_next   = adler_low;
    adler_high_next  = adler_high;
    raw_left_next    = raw_left;
    block_left_next  = block_left;
    column_next      = column;

    unique case (item_mode)
      MODE_BEGIN: begin
        if (step == 4'd0) begin
          crc_next = CRC_INIT;
        end
        if (step >= BEGIN_LEN_STEP) begin
          emit = 1'b1;
          if (step < BEGIN_TAG_STEP) begin
            emit_byte = be32_byte(len_reg, 2'(step - BEGIN_LEN_STEP));
          end else if (step < BEGIN_ZLIB_STEP) begin
            emit_byte = be32_byte(CHUNK_TYPE, 2'(step - BEGIN_TAG_STEP));
            fold      = 1'b1;
          end else begin
            emit_byte = (step == BEGIN_LAST_STEP) ? ZLIB_FLG : ZLIB_CMF;
            fold      = 1'b1;
          end
        end
        if (step == BEGIN_LAST_STEP) begin
          emit_last       = 1'b1;
          done            = 1'b1;
          adler_low_next  = 16'd1;
          adler_high_next = 16'd0;
          raw_left_next   = raw_reg;
          block_left_next = 16'd0;
          column_next     = 16'd0;
        end
      end

      MODE_PIXEL: begin
        emit = 1'b1;
        fold = 1'b1;
        if (in_hdr) begin
          emit_byte = hdr_byte(bfinal, blen, step[2:0]);
          if (step == HDR_LAST_STEP) begin
            block_left_next = blen;
            step_next       = 4'd0;
          end
        end else begin
          emit_byte       = raw_b;
          step_next       = 4'd0;
          block_left_next = (block_left != 16'd0) ? block_left - 16'd1 : block_left;
          raw_left_next   = (raw_left != 32'd0) ? raw_left - 32'd1 : raw_left;
          adler_low_next  = lo_mod[15:0];
          adler_high_next = hi_mod[15:0];
          if (filter_now) begin
            filter_done_next = 1'b1;
          end else begin
            emit_last   = 1'b1;
            done        = 1'b1;
            column_next = (col_inc >= {1'b0, image_width}) ? 16'd0 : col_inc[15:0];
          end
        end
      end

      MODE_END: begin
        emit = 1'b1;
        if (step < END_CRC_STEP) begin
          emit_byte = be32_byte({adler_high, adler_low}, step[1:0]);
          fold      = 1'b1;
        end else begin
          emit_byte = be32_byte(~crc, step[1:0]);
        end
        if (step == END_LAST_STEP) begin
          emit_last = 1'b1;
          done      = 1'b1;
        end
      end

      MODE_IGNORE: begin
        done = 1'b1;
      end
    endcase

    if (fold) begin
      crc_next = crc_byte(crc, emit_byte);
    end
  end

  assign items.ready = !item_valid || (adv && done);

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      crc         <= CRC_INIT;
      adler_low   <= 16'd1;
      adler_high  <= 16'd0;
      raw_left    <= 32'd0;
      block_left  <= 16'd0;
      column      <= 16'd0;
      item_valid  <= 1'b0;
      step        <= 4'd0;
      filter_done <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (adv) begin
        crc         <= crc_next;
        adler_low   <= adler_low_next;
        adler_high  <= adler_high_next;
        raw_left    <= raw_left_next;
        block_left  <= block_left_next;
        column      <= column_next;
      end
      // A newly taken transaction restarts the sequencer
      if (items.valid && items.ready) begin
        item_valid  <= 1'b1;
        step        <= 4'd0;
        filter_done <= 1'b0;
      end else if (adv) begin
        step        <= step_next;
        filter_done <= filter_done_next;
        if (done) begin
          item_valid <= 1'b0;
        end
      end
      if (adv && emit) begin
        out_valid <= 1'b1;
      end else if (stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      item_mode  <= mode_t'(items.mode);
      item_pixel <= items.pixel_index;
    end
    if (adv && emit) begin
      out_byte <= emit_byte;
      out_last <= emit_last;
    end
  end

  assign stream.valid    = out_valid;
  assign stream.out_byte = out_byte;
  assign stream.run_last = out_last;

  // Checks
  `PNGIDAT_ASSERT_ALWAYS(a_adler_low_range, adler_low < ADLER_MOD[15:0],
    "adler_low left the modulus range")
  `PNGIDAT_ASSERT_ALWAYS(a_adler_high_range, adler_high < ADLER_MOD[15:0],
    "adler_high left the modulus range")
  `PNGIDAT_ASSERT_ALWAYS(a_block_within_raw, {16'd0, block_left} <= raw_left,
    "stored block outlasts the remaining raw bytes")
  `PNGIDAT_ASSERT_IMPLIES(a_hdr_step, item_valid && item_mode == MODE_PIXEL && step != 4'd0,
    in_hdr, "pixel sequencer mid-header without a pending block header")

endmodule

### tb/png_idat_stream_check.sv
// Predicts and checks the IDAT chunk byte stream of the stored-zlib encoder.
module png_idat_stream_check
  import pngidat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_pixel,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  output int          mismatches,
  output int          bytes_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } chunk_byte_t;

  // Bytes owed by the encoder, oldest first
  chunk_byte_t chunk_bytes_due[$];

  // Shadow of the image size registers
  logic [15:0] width_reg;
  logic [15:0] height_reg;

  // Shadow of the encoder state
  logic [31:0] crc_reg;
  logic [15:0] adler_lo;
  logic [15:0] adler_hi;
  logic [31:0] raw_left;
  logic [15:0] block_left;
  logic [15:0] column;

  // Queue one chunk byte, optionally folding it into the CRC
  task put_chunk_byte(input logic [7:0] b, input bit fold);
    chunk_byte_t e;
    if (fold) begin
      crc_reg = crc_reg ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        crc_reg = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
      end
    end
    e.data = b;
    e.last = 1'b0;
    chunk_bytes_due.push_back(e);
  endtask

  task put_word_be(input logic [31:0] w, input bit fold);
    put_chunk_byte(w[31:24], fold);
    put_chunk_byte(w[23:16], fold);
    put_chunk_byte(w[15:8], fold);
    put_chunk_byte(w[7:0], fold);
  endtask

  // One byte of zlib payload: stored-block header when a block opens, Adler update
  task put_raw_byte(input logic [7:0] b);
    logic [31:0] blen;
    logic [15:0] nlen;
    if (block_left == 16'd0 && raw_left != 32'd0) begin
      blen = (raw_left > MAX_BLOCK_BYTES) ? MAX_BLOCK_BYTES : raw_left;
      nlen = ~blen[15:0];
      put_chunk_byte({7'd0, raw_left <= MAX_BLOCK_BYTES}, 1'b1);
      put_chunk_byte(blen[7:0], 1'b1);
      put_chunk_byte(blen[15:8], 1'b1);
      put_chunk_byte(nlen[7:0], 1'b1);
      put_chunk_byte(nlen[15:8], 1'b1);
      block_left = blen[15:0];
    end
    put_chunk_byte(b, 1'b1);
    if (block_left != 16'd0) block_left = block_left - 16'd1;
    if (raw_left != 32'd0) raw_left = raw_left - 32'd1;
    adler_lo = 16'((32'(adler_lo) + 32'(b)) % 32'(ADLER_MOD));
    adler_hi = 16'((32'(adler_hi) + 32'(adler_lo)) % 32'(ADLER_MOD));
  endtask

  // Expected bytes of one accepted input transaction
  task predict_item(input mode_t m, input logic [7:0] p);
    int          first;
    logic [31:0] raw;
    logic [31:0] blocks;
    chunk_byte_t tail;
    first = chunk_bytes_due.size();
    case (m)
      MODE_BEGIN: begin
        raw = 32'(height_reg) * (32'd1 + 32'(width_reg));
        blocks = raw / MAX_BLOCK_BYTES;
        if (raw % MAX_BLOCK_BYTES != 32'd0) blocks = blocks + 32'd1;
        if (blocks == 32'd0) blocks = 32'd1;
        put_word_be(raw + 32'd5 * blocks + 32'd6, 1'b0);
        crc_reg = CRC_INIT;
        put_word_be(CHUNK_TYPE, 1'b1);
        put_chunk_byte(ZLIB_CMF, 1'b1);
        put_chunk_byte(ZLIB_FLG, 1'b1);
        adler_lo = 16'd1;
        adler_hi = 16'd0;
        raw_left = raw;
        block_left = 16'd0;
        column = 16'd0;
      end
      MODE_PIXEL: begin
        // filter type byte at each row start
        if (column == 16'd0) put_raw_byte(8'h00);
        put_raw_byte(p);
        if (32'(column) + 32'd1 >= 32'(width_reg)) column = 16'd0;
        else column = column + 16'd1;
      end
      MODE_END: begin
        put_word_be({adler_hi, adler_lo}, 1'b1);
        put_word_be(~crc_reg, 1'b0);
      end
      default: ;
    endcase
    if (chunk_bytes_due.size() > first) begin
      tail = chunk_bytes_due.pop_back();
      tail.last = 1'b1;
      chunk_bytes_due.push_back(tail);
    end
  endtask

  always @(posedge clk) begin
    chunk_byte_t want;
    if (rst) begin
      width_reg = 16'd1;
      height_reg = 16'd1;
      crc_reg = CRC_INIT;
      adler_lo = 16'd1;
      adler_hi = 16'd0;
      raw_left = 32'd0;
      block_left = 16'd0;
      column = 16'd0;
      mismatches = 0;
      chunk_bytes_due.delete();
    end else begin
      // compare output transaction against the oldest expectation
      if (out_valid && out_ready) begin
        if (chunk_bytes_due.size() == 0) begin
          $display("%0t: unexpected chunk byte %02h (run_last %0b), none expected",
                   $time, out_byte, out_last);
          mismatches++;
        end else begin
          want = chunk_bytes_due.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, out_byte);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $display("%0t: run_last mismatch: expected %0b, actual %0b",
                     $time, want.last, out_last);
            mismatches++;
          end
        end
      end
      if (cfg_write) begin
        if (cfg_index == REG_IMAGE_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (in_valid && in_ready) predict_item(mode_t'(in_mode), in_pixel);
    end
    bytes_pending = chunk_bytes_due.size();
  end

endmodule

### tb/png_idat_stored_zlib_encoder_top_tb.sv
// Stimulus and verdict for the IDAT stored-zlib encoder.
module png_idat_stored_zlib_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pngidat_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int bytes_pending;
  int items_sent;      // non-ignored input transactions
  bit sender_gaps_on;

  pngidat_in_if  items_ch ();
  pngidat_out_if stream_ch ();

  png_idat_stored_zlib_encoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (items_ch),
    .stream    (stream_ch)
  );

  png_idat_stream_check u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (items_ch.valid),
    .in_ready      (items_ch.ready),
    .in_mode       (items_ch.mode),
    .in_pixel      (items_ch.pixel_index),
    .out_valid     (stream_ch.valid),
    .out_ready     (stream_ch.ready),
    .out_byte      (stream_ch.out_byte),
    .out_last      (stream_ch.run_last),
    .mismatches    (mismatches),
    .bytes_pending (bytes_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Output side back-pressure, in stretches with stalls on or off at random
  initial begin : stream_ready_drive
    int hold;
    int span;
    bit stalls_on;
    stream_ch.ready = 1'b0;
    hold = 0;
    span = 0;
    stalls_on = 1'b1;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        stalls_on = ($urandom_range(0, 2) != 0);
        span = $urandom_range(50, 400);
      end
      span--;
      if (hold > 0) begin
        stream_ch.ready = 1'b0;
        hold--;
      end else begin
        stream_ch.ready = 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) hold = idle_len();
      end
    end
  end

  // One input transaction; returns at the falling edge after acceptance
  task automatic push_item(input mode_t m, input logic [7:0] p);
    int gap;
    gap = sender_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      items_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_ch.valid = 1'b1;
    items_ch.mode = m;
    items_ch.pixel_index = p;
    do @(posedge clk); while (!items_ch.ready);
    @(negedge clk);
    if (m != MODE_IGNORE) items_sent++;
  endtask

  // Hold the sender until all owed bytes are out, then let the pipe settle
  task automatic wait_drained(input int settle);
    items_ch.valid = 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
    cfg_write = 1'b1;
    cfg_index = r;
    cfg_data = v;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_image(input logic [15:0] w, input logic [15:0] h);
    wait_drained(16);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  function automatic logic [15:0] pick_extreme();
    return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1;
  endfunction

  initial begin : stimulus
    int          r;
    int          npix;
    int          start_count;
    logic [15:0] w;
    logic [15:0] h;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_IMAGE_WIDTH;
    cfg_data = 16'd0;
    items_ch.valid = 1'b0;
    items_ch.mode = MODE_IGNORE;
    items_ch.pixel_index = 8'd0;
    items_sent = 0;
    sender_gaps_on = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset sizes: pixel and end with no begin, ignored mode, excess pixels
    push_item(MODE_PIXEL, 8'h00);
    push_item(MODE_END, 8'h00);
    push_item(MODE_IGNORE, 8'hFF);
    push_item(MODE_BEGIN, 8'h00);
    push_item(MODE_PIXEL, 8'hFF);
    push_item(MODE_PIXEL, 8'h5A);
    push_item(MODE_END, 8'h00);

    // Largest image: length wraps, first block header is not final
    set_image(16'hFFFF, 16'hFFFF);
    push_item(MODE_BEGIN, 8'h00);
    push_item(MODE_PIXEL, 8'hAA);
    push_item(MODE_PIXEL, 8'h55);
    push_item(MODE_IGNORE, 8'h00);
    push_item(MODE_END, 8'h00);

    // Small full image, sender held mid-image until the stream drains
    set_image(16'd3, 16'd2);
    push_item(MODE_BEGIN, 8'h00);
    for (int i = 0; i < 6; i++) begin
      if (i == 3) wait_drained(0);
      push_item(MODE_PIXEL, 8'($urandom_range(0, 255)));
    end
    push_item(MODE_END, 8'h00);

    // Random images, mostly well formed
    start_count = items_sent;
    while (items_sent - start_count < 240) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        w = 16'($urandom_range(1, 6));
        h = 16'($urandom_range(1, 5));
        npix = int'(w) * int'(h);
      end else if (r < 90) begin
        w = 16'($urandom_range(1, 65535));
        h = 16'($urandom_range(1, 65535));
        npix = $urandom_range(1, 10);
      end else begin
        w = pick_extreme();
        h = pick_extreme();
        npix = $urandom_range(1, 10);
      end
      set_image(w, h);
      sender_gaps_on = ($urandom_range(0, 3) != 0);

      r = $urandom_range(0, 99);
      if (r < 10) npix = npix + $urandom_range(1, 3);
      else if (r < 20) npix = $urandom_range(0, npix);
      if (r < 92 || r >= 97) push_item(MODE_BEGIN, 8'h00);
      if (r >= 97) push_item(MODE_BEGIN, 8'h00);
      for (int i = 0; i < npix; i++) begin
        if ($urandom_range(0, 99) < 5) push_item(MODE_IGNORE, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 3) wait_drained(0);
        push_item(MODE_PIXEL, 8'($urandom_range(0, 255)));
      end
      push_item(MODE_END, 8'h00);
      if ($urandom_range(0, 99) < 5) push_item(MODE_END, 8'h00);
    end

    // Drain and verdict
    sender_gaps_on = 1'b1;
    items_ch.valid = 1'b0;
    while (bytes_pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
